// File: sv/stx_etx_bcc_command_link_top_macros.svh
// Assertion macros of the command link RTL, used by the result register.
`ifndef STX_ETX_BCC_COMMAND_LINK_TOP_MACROS_SVH
`define STX_ETX_BCC_COMMAND_LINK_TOP_MACROS_SVH

// Implication checked at every rising clk edge outside reset.
`define SEBCL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same check for a property that is not an implication.
`define SEBCL_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`endif

// File: sv/sebcl_pkg.sv
// Types, codes and helper functions of the STX/ETX/BCC command link.
package sebcl_pkg;

	localparam int MAX_FRAME_DEF = 256;

	localparam logic [7:0] CH_ACK  = 8'h06;
	localparam logic [7:0] CH_ENQ  = 8'h05;
	localparam logic [7:0] CH_STX  = 8'h02;
	localparam logic [7:0] CH_ETX  = 8'h03;
	localparam logic [7:0] DIGIT0  = 8'h30;
	localparam logic [7:0] NO_ADDR = 8'hff;

	localparam logic [7:0]  ADDR_RST     = 8'hff;
	localparam logic [15:0] ACK_TO_RST   = 16'd1000;
	localparam logic [15:0] RESP_TO_RST  = 16'd7000;

	localparam logic [1:0] CFG_ADDR    = 2'd0;
	localparam logic [1:0] CFG_ACK_TO  = 2'd1;
	localparam logic [1:0] CFG_RESP_TO = 2'd2;

	localparam logic [1:0] REQ_CMD  = 2'd0;
	localparam logic [1:0] REQ_RX   = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;

	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_DATA   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_ACK_TO  = 3'd1;
	localparam logic [2:0] ST_BAD_ACK = 3'd2;
	localparam logic [2:0] ST_RESP_TO = 3'd3;
	localparam logic [2:0] ST_OVF     = 3'd4;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SEND,
		PH_ACK,
		PH_RESP
	} phase_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] cmd_byte;
		logic       cmd_last;
		logic       want_response;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [2:0] status;
		logic [7:0] count;
		logic       last;
	} res_t;

	typedef struct packed {
		res_t [3:0] ent;
		logic [2:0] cnt;
	} batch_t;

	typedef struct packed {
		logic [7:0]  addr;
		logic [15:0] ack_limit;
		logic [15:0] resp_limit;
	} cfg_t;

	function automatic logic [4:0] div10(input logic [7:0] a);
		logic [18:0] p;
		p = {11'd0, a} * 19'd205;
		return p[15:11];
	endfunction

	function automatic logic [7:0] digit_tens(input logic [7:0] a);
		return {3'd0, div10(a)} + DIGIT0;
	endfunction

	function automatic logic [7:0] digit_ones(input logic [7:0] a);
		logic [7:0] t10;
		t10 = {3'd0, div10(a)} * 8'd10;
		return (a - t10) + DIGIT0;
	endfunction

	function automatic res_t mk_byte(input logic [1:0] kind, input logic [7:0] b);
		res_t r;
		r = '0;
		r.kind = kind;
		r.data = b;
		return r;
	endfunction

	function automatic res_t mk_status(input logic [2:0] code, input logic [7:0] n);
		res_t r;
		r = '0;
		r.kind = KIND_STATUS;
		r.status = code;
		r.count = n;
		r.last = 1'b1;
		return r;
	endfunction

endpackage

// File: sv/stx_etx_bcc_command_link_top.sv
// Top level of the STX/ETX/BCC command link, host side.
//
//  channel | handshake          | payload
//  req     | req_valid/req_stall | req_type cmd_byte cmd_last want_response rx_byte
//  res     | res_valid/res_stall | out_kind out_byte status_code data_count is_last
//  cfg     | cfg_valid/cfg_ready | cfg_index cfg_data
//
// An accepted item lands in the input register and is processed from there into
// the result register, which hands out its 0 to 4 results one per cycle when
// res_stall is low. A new item is loaded only when the result register is empty
// or its last result goes out; the result register's single output port sets the pace.
// Reset is asynchronous and needs no clearing pass; cfg_ready is always high.
// A res_stall holds the result register, which in turn holds the input register.
module stx_etx_bcc_command_link_top #(
	parameter int MAX_FRAME = sebcl_pkg::MAX_FRAME_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  cmd_byte,
	input  logic        cmd_last,
	input  logic        want_response,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  out_kind,
	output logic [7:0]  out_byte,
	output logic [2:0]  status_code,
	output logic [7:0]  data_count,
	output logic        is_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import sebcl_pkg::*;

	cfg_t    cfg_q;
	req_t    item_s1;
	logic    valid_s1;
	logic    free, go;
	batch_t  batch;
	res_t    res;

	assign cfg_ready = 1'b1;
	assign go        = valid_s1 && free;
	assign req_stall = valid_s1 && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.addr       <= ADDR_RST;
			cfg_q.ack_limit  <= ACK_TO_RST;
			cfg_q.resp_limit <= RESP_TO_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ADDR:    cfg_q.addr       <= cfg_data[7:0];
				CFG_ACK_TO:  cfg_q.ack_limit  <= cfg_data;
				CFG_RESP_TO: cfg_q.resp_limit <= cfg_data;
				default:     cfg_q            <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!req_stall)
			valid_s1 <= req_valid;
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1.req_type      <= req_type;
			item_s1.cmd_byte      <= cmd_byte;
			item_s1.cmd_last      <= cmd_last;
			item_s1.want_response <= want_response;
			item_s1.rx_byte       <= rx_byte;
		end
	end

	sebcl_core #(
		.MAX_FRAME (MAX_FRAME)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.item   (item_s1),
		.cfg    (cfg_q),
		.batch  (batch)
	);

	sebcl_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (go),
		.batch     (batch),
		.free      (free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	assign out_kind    = res.kind;
	assign out_byte    = res.data;
	assign status_code = res.status;
	assign data_count  = res.count;
	assign is_last     = res.last;

endmodule

// File: sv/sebcl_core.sv
// Transaction state machine: frames commands, checks acknowledge, parses response.
module sebcl_core #(
	parameter int MAX_FRAME = sebcl_pkg::MAX_FRAME_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  sebcl_pkg::req_t     item,
	input  sebcl_pkg::cfg_t     cfg,
	output sebcl_pkg::batch_t   batch
);
	import sebcl_pkg::*;

	localparam int POS_W = $clog2(MAX_FRAME + 1);
	localparam int EXT_W = POS_W + 2;

	phase_t             phase_q, phase_d;
	logic [7:0]         txc_q, txc_d;
	logic [7:0]         rxc_q, rxc_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [15:0]        tmr_q, tmr_d;
	logic               want_q, want_d;
	logic [7:0]         held_q, held_d;
	logic [7:0]         dcnt_q, dcnt_d;

	logic               addressed, is_cmd, is_rx, is_tick;
	logic [7:0]         tens, ones, bcc;
	logic [15:0]        tmr_inc, limit;
	logic               pos_zero, tick_exp, send_ovf;
	logic [POS_W-1:0]   pos_inc;
	logic               ack_done, bad_ack;
	logic [7:0]         ack_first;
	logic               pos_ge3, term, is_data, resp_ovf;
	logic [7:0]         dcnt_nx;

	assign addressed = cfg.addr != NO_ADDR;
	assign is_cmd    = item.req_type == REQ_CMD;
	assign is_rx     = item.req_type == REQ_RX;
	assign is_tick   = item.req_type == REQ_TICK;
	assign tens      = digit_tens(cfg.addr);
	assign ones      = digit_ones(cfg.addr);
	assign bcc       = txc_q ^ item.cmd_byte ^ CH_ETX;

	assign tmr_inc   = (tmr_q != 16'hffff) ? tmr_q + 16'd1 : tmr_q;
	assign limit     = (phase_q == PH_ACK) ? cfg.ack_limit : cfg.resp_limit;
	assign pos_zero  = pos_q == '0;
	assign tick_exp  = is_tick && pos_zero && (tmr_inc >= limit);
	assign send_ovf  = ({2'b00, pos_q} + EXT_W'(3)) > EXT_W'(MAX_FRAME);
	assign pos_inc   = pos_q + POS_W'(1);

	assign ack_first = pos_zero ? item.rx_byte : held_q;
	assign ack_done  = pos_inc >= (addressed ? POS_W'(3) : POS_W'(1));
	assign bad_ack   = ack_first != CH_ACK;

	assign pos_ge3   = pos_q >= POS_W'(3);
	assign term      = item.rx_byte == rxc_q;
	assign is_data   = pos_q >= (addressed ? POS_W'(6) : POS_W'(4));
	assign resp_ovf  = ({1'b0, pos_q} + (POS_W + 1)'(1)) >= (POS_W + 1)'(MAX_FRAME);
	assign dcnt_nx   = (is_data && dcnt_q != 8'hff) ? dcnt_q + 8'd1 : dcnt_q;

	always_comb begin
		phase_d = phase_q;
		txc_d   = txc_q;
		rxc_d   = rxc_q;
		pos_d   = pos_q;
		tmr_d   = tmr_q;
		want_d  = want_q;
		held_d  = held_q;
		dcnt_d  = dcnt_q;
		case (phase_q)
			PH_IDLE: if (is_cmd) begin
				want_d  = item.want_response;
				txc_d   = CH_STX ^ item.cmd_byte ^ (addressed ? (tens ^ ones) : 8'h00);
				pos_d   = addressed ? POS_W'(4) : POS_W'(2);
				phase_d = PH_SEND;
			end
			PH_SEND: if (is_cmd) begin
				if (send_ovf) begin
					phase_d = PH_IDLE;
				end else if (item.cmd_last) begin
					txc_d   = bcc;
					pos_d   = '0;
					tmr_d   = '0;
					phase_d = PH_ACK;
				end else begin
					txc_d = txc_q ^ item.cmd_byte;
					pos_d = pos_inc;
				end
			end
			PH_ACK: begin
				if (is_tick && pos_zero) begin
					tmr_d = tmr_inc;
					if (tick_exp)
						phase_d = PH_IDLE;
				end else if (is_rx) begin
					held_d = ack_first;
					pos_d  = pos_inc;
					if (ack_done) begin
						if (bad_ack || !want_q) begin
							phase_d = PH_IDLE;
						end else begin
							phase_d = PH_RESP;
							pos_d   = '0;
							rxc_d   = '0;
							tmr_d   = '0;
							dcnt_d  = '0;
							held_d  = '0;
						end
					end
				end
			end
			PH_RESP: begin
				if (is_tick && pos_zero) begin
					tmr_d = tmr_inc;
					if (tick_exp)
						phase_d = PH_IDLE;
				end else if (is_rx) begin
					if (pos_ge3 && term) begin
						phase_d = PH_IDLE;
					end else if (pos_ge3 && resp_ovf) begin
						dcnt_d  = dcnt_nx;
						phase_d = PH_IDLE;
					end else begin
						if (pos_ge3)
							dcnt_d = dcnt_nx;
						held_d = item.rx_byte;
						rxc_d  = rxc_q ^ item.rx_byte;
						pos_d  = pos_inc;
					end
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	always_comb begin
		batch = '0;
		case (phase_q)
			PH_IDLE: if (is_cmd) begin
				batch.ent[0] = mk_byte(KIND_TX, CH_STX);
				if (addressed) begin
					batch.ent[1] = mk_byte(KIND_TX, tens);
					batch.ent[2] = mk_byte(KIND_TX, ones);
					batch.ent[3] = mk_byte(KIND_TX, item.cmd_byte);
					batch.cnt    = 3'd4;
				end else begin
					batch.ent[1] = mk_byte(KIND_TX, item.cmd_byte);
					batch.cnt    = 3'd2;
				end
			end
			PH_SEND: if (is_cmd) begin
				if (send_ovf) begin
					batch.ent[0] = mk_status(ST_OVF, 8'd0);
					batch.cnt    = 3'd1;
				end else if (item.cmd_last) begin
					batch.ent[0] = mk_byte(KIND_TX, item.cmd_byte);
					batch.ent[1] = mk_byte(KIND_TX, CH_ETX);
					batch.ent[2] = mk_byte(KIND_TX, bcc);
					batch.cnt    = 3'd3;
				end else begin
					batch.ent[0] = mk_byte(KIND_TX, item.cmd_byte);
					batch.cnt    = 3'd1;
				end
			end
			PH_ACK: begin
				if (tick_exp) begin
					batch.ent[0] = mk_status(ST_ACK_TO, 8'd0);
					batch.cnt    = 3'd1;
				end else if (is_rx && ack_done) begin
					if (bad_ack) begin
						batch.ent[0] = mk_status(ST_BAD_ACK, 8'd0);
						batch.cnt    = 3'd1;
					end else if (addressed) begin
						batch.ent[0] = mk_byte(KIND_TX, CH_ENQ);
						batch.ent[1] = mk_byte(KIND_TX, tens);
						batch.ent[2] = mk_byte(KIND_TX, ones);
						batch.ent[3] = mk_status(ST_OK, 8'd0);
						batch.cnt    = want_q ? 3'd3 : 3'd4;
					end else begin
						batch.ent[0] = mk_byte(KIND_TX, CH_ENQ);
						batch.ent[1] = mk_status(ST_OK, 8'd0);
						batch.cnt    = want_q ? 3'd1 : 3'd2;
					end
				end
			end
			PH_RESP: begin
				if (tick_exp) begin
					batch.ent[0] = mk_status(ST_RESP_TO, 8'd0);
					batch.cnt    = 3'd1;
				end else if (is_rx && pos_ge3) begin
					if (term) begin
						batch.ent[0] = mk_status(ST_OK, dcnt_q);
						batch.cnt    = 3'd1;
					end else if (is_data) begin
						batch.ent[0] = mk_byte(KIND_DATA, held_q);
						batch.ent[1] = mk_status(ST_OVF, dcnt_nx);
						batch.cnt    = resp_ovf ? 3'd2 : 3'd1;
					end else if (resp_ovf) begin
						batch.ent[0] = mk_status(ST_OVF, dcnt_q);
						batch.cnt    = 3'd1;
					end
				end
			end
			default: batch = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			txc_q   <= '0;
			rxc_q   <= '0;
			pos_q   <= '0;
			tmr_q   <= '0;
			want_q  <= 1'b0;
			held_q  <= '0;
			dcnt_q  <= '0;
		end else if (go) begin
			phase_q <= phase_d;
			txc_q   <= txc_d;
			rxc_q   <= rxc_d;
			pos_q   <= pos_d;
			tmr_q   <= tmr_d;
			want_q  <= want_d;
			held_q  <= held_d;
			dcnt_q  <= dcnt_d;
		end
	end

endmodule

// File: sv/sebcl_obuf.sv
// Result register: holds one item's results and hands them out one per transfer.
`include "stx_etx_bcc_command_link_top_macros.svh"
module sebcl_obuf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  sebcl_pkg::batch_t  batch,
	output logic               free,
	output logic               res_valid,
	input  logic               res_stall,
	output sebcl_pkg::res_t    res
);
	import sebcl_pkg::*;

	res_t [3:0]  ent_q;
	logic [2:0]  cnt_q;
	logic [1:0]  idx_q;
	logic        xfer, at_end, take;

	assign res_valid = cnt_q != 3'd0;
	assign res       = ent_q[idx_q];
	assign xfer      = res_valid && !res_stall;
	assign at_end    = {1'b0, idx_q} == (cnt_q - 3'd1);
	assign free      = !res_valid || (xfer && at_end);
	assign take      = load && (batch.cnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (take) begin
			cnt_q <= batch.cnt;
			idx_q <= '0;
		end else if (xfer) begin
			if (at_end) begin
				cnt_q <= '0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			ent_q <= batch.ent;
	end

	`SEBCL_ASSERT(a_load_when_free, load |-> free, "result register overwritten while busy")
	`SEBCL_ASSERT_ALWAYS(a_idx_in_range, !res_valid || ({1'b0, idx_q} < cnt_q), "read index past count")
	`SEBCL_ASSERT(a_drain_empties, (xfer && at_end && !take) |=> !res_valid, "valid held after last transfer")
	`SEBCL_ASSERT(a_last_is_status, (res_valid && res.last) |-> at_end, "status not last of its item")

endmodule

// File: test/stx_etx_bcc_command_link_checker.sv
`timescale 1ns / 1ps
// Monitor for the command link: predicts every result from accepted requests and compares.
module stx_etx_bcc_command_link_checker #(
	parameter int MAX_FRAME = sebcl_pkg::MAX_FRAME_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  cmd_byte,
	input  logic        cmd_last,
	input  logic        want_response,
	input  logic [7:0]  rx_byte,
	input  logic        res_valid,
	input  logic        res_stall,
	input  logic [1:0]  out_kind,
	input  logic [7:0]  out_byte,
	input  logic [2:0]  status_code,
	input  logic [7:0]  data_count,
	input  logic        is_last,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          errors,
	output int          pending
);
	import sebcl_pkg::*;

	res_t link_outputs_due[$];
	int mismatch_n = 0;

	logic [7:0]  addr_r = ADDR_RST;
	logic [15:0] ack_lim = ACK_TO_RST;
	logic [15:0] resp_lim = RESP_TO_RST;

	phase_t      ph = PH_IDLE;
	logic [7:0]  tx_bcc = '0;
	logic [7:0]  rx_bcc = '0;
	logic [15:0] pos = '0;
	logic [15:0] ticks = '0;
	logic        want_r = 1'b0;
	logic [7:0]  held = '0;
	logic [7:0]  n_data = '0;

	task automatic report_mismatch(input string what);
		mismatch_n++;
		if (mismatch_n <= 100)
			$display("%0t checker: mismatch: %s", $realtime, what);
	endtask

	function automatic logic has_addr();
		return addr_r != NO_ADDR;
	endfunction

	function automatic logic [7:0] tens_char();
		return addr_r / 8'd10 + DIGIT0;
	endfunction

	function automatic logic [7:0] ones_char();
		return addr_r % 8'd10 + DIGIT0;
	endfunction

	function automatic logic tick_out(input logic [15:0] lim);
		if (ticks != 16'hffff)
			ticks++;
		return ticks >= lim;
	endfunction

	task automatic emit(input logic [1:0] kind, input logic [7:0] b, input logic [2:0] st,
			input logic [7:0] n, input logic fin);
		res_t r;
		r.kind = kind;
		r.data = b;
		r.status = st;
		r.count = n;
		r.last = fin;
		link_outputs_due.push_back(r);
	endtask

	task automatic frame_byte(input logic [7:0] b);
		tx_bcc = tx_bcc ^ b;
		emit(KIND_TX, b, ST_OK, 8'd0, 1'b0);
	endtask

	task automatic close_link(input logic [2:0] st, input logic [7:0] n);
		ph = PH_IDLE;
		emit(KIND_STATUS, 8'd0, st, n, 1'b1);
	endtask

	task automatic step_link(input logic [1:0] kind, input logic [7:0] cb, input logic lst,
			input logic want, input logic [7:0] rb);
		int hdr;
		hdr = has_addr() ? 5 : 3;
		case (ph)
		PH_IDLE: if (kind == REQ_CMD) begin
			want_r = want;
			tx_bcc = '0;
			frame_byte(CH_STX);
			pos = 16'd1;
			if (has_addr()) begin
				frame_byte(tens_char());
				frame_byte(ones_char());
				pos = 16'd3;
			end
			frame_byte(cb);
			pos++;
			ph = PH_SEND;
		end
		PH_SEND: if (kind == REQ_CMD) begin
			if (int'(pos) + 3 > MAX_FRAME) begin
				close_link(ST_OVF, 8'd0);
			end else begin
				frame_byte(cb);
				pos++;
				if (lst) begin
					frame_byte(CH_ETX);
					emit(KIND_TX, tx_bcc, ST_OK, 8'd0, 1'b0);
					ph = PH_ACK;
					pos = '0;
					ticks = '0;
				end
			end
		end
		PH_ACK: if (kind == REQ_TICK) begin
			if (pos == 16'd0 && tick_out(ack_lim))
				close_link(ST_ACK_TO, 8'd0);
		end else if (kind == REQ_RX) begin
			if (pos == 16'd0)
				held = rb;
			pos++;
			if (pos >= (has_addr() ? 16'd3 : 16'd1)) begin
				if (held != CH_ACK) begin
					close_link(ST_BAD_ACK, 8'd0);
				end else begin
					emit(KIND_TX, CH_ENQ, ST_OK, 8'd0, 1'b0);
					if (has_addr()) begin
						emit(KIND_TX, tens_char(), ST_OK, 8'd0, 1'b0);
						emit(KIND_TX, ones_char(), ST_OK, 8'd0, 1'b0);
					end
					if (!want_r) begin
						close_link(ST_OK, 8'd0);
					end else begin
						ph = PH_RESP;
						pos = '0;
						rx_bcc = '0;
						ticks = '0;
						n_data = '0;
						held = '0;
					end
				end
			end
		end
		PH_RESP: if (kind == REQ_TICK) begin
			if (pos == 16'd0 && tick_out(resp_lim))
				close_link(ST_RESP_TO, 8'd0);
		end else if (kind == REQ_RX) begin
			if (pos >= 16'd3 && rb == rx_bcc) begin
				close_link(ST_OK, n_data);
			end else begin
				if (pos >= 16'd3 && int'(pos) - 1 >= hdr) begin
					emit(KIND_DATA, held, ST_OK, 8'd0, 1'b0);
					if (n_data != 8'hff)
						n_data++;
				end
				if (pos >= 16'd3 && int'(pos) + 1 >= MAX_FRAME) begin
					close_link(ST_OVF, n_data);
				end else begin
					held = rb;
					rx_bcc = rx_bcc ^ rb;
					pos++;
				end
			end
		end
		default: ph = PH_IDLE;
		endcase
	endtask

	task automatic check_transfer();
		res_t seen;
		res_t due;
		seen = {out_kind, out_byte, status_code, data_count, is_last};
		if (link_outputs_due.size() == 0) begin
			report_mismatch($sformatf("unpredicted result kind %0d byte %02h status %0d",
				seen.kind, seen.data, seen.status));
			return;
		end
		due = link_outputs_due.pop_front();
		if (seen.kind !== due.kind)
			report_mismatch($sformatf("out_kind %0d, predicted %0d", seen.kind, due.kind));
		if (seen.data !== due.data)
			report_mismatch($sformatf("out_byte %02h, predicted %02h", seen.data, due.data));
		if (seen.status !== due.status)
			report_mismatch($sformatf("status_code %0d, predicted %0d", seen.status, due.status));
		if (seen.count !== due.count)
			report_mismatch($sformatf("data_count %0d, predicted %0d", seen.count, due.count));
		if (seen.last !== due.last)
			report_mismatch($sformatf("is_last %0d, predicted %0d", seen.last, due.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_outputs_due.delete();
			addr_r = ADDR_RST;
			ack_lim = ACK_TO_RST;
			resp_lim = RESP_TO_RST;
			ph = PH_IDLE;
			tx_bcc = '0;
			rx_bcc = '0;
			pos = '0;
			ticks = '0;
			want_r = 1'b0;
			held = '0;
			n_data = '0;
			pending <= 0;
		end else begin
			if (res_valid && !res_stall)
				check_transfer();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_ADDR:    addr_r = cfg_data[7:0];
				CFG_ACK_TO:  ack_lim = cfg_data;
				CFG_RESP_TO: resp_lim = cfg_data;
				default: ;
				endcase
			end
			if (req_valid && !req_stall)
				step_link(req_type, cmd_byte, cmd_last, want_response, rx_byte);
			pending <= link_outputs_due.size();
		end
		errors <= mismatch_n;
	end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the STX/ETX/BCC command link, with the monitor beside the block.
module testbench;
	import sebcl_pkg::*;

	localparam int FRAME = MAX_FRAME_DEF;
	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam logic [1:0] CFG_NONE = 2'd3;
	localparam logic [7:0] NAK = 8'h15;
	localparam logic [3:0] IGN_IDLE = (4'b1 << REQ_RX) | (4'b1 << REQ_TICK) | (4'b1 << REQ_NONE);
	localparam logic [3:0] IGN_WAIT = (4'b1 << REQ_CMD) | (4'b1 << REQ_NONE);
	localparam logic [3:0] IGN_BUSY = (4'b1 << REQ_CMD) | (4'b1 << REQ_TICK) | (4'b1 << REQ_NONE);

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [1:0]  req_type = REQ_NONE;
	logic [7:0]  cmd_byte = '0;
	logic        cmd_last = 1'b0;
	logic        want_response = 1'b0;
	logic [7:0]  rx_byte = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [1:0]  out_kind;
	logic [7:0]  out_byte;
	logic [2:0]  status_code;
	logic [7:0]  data_count;
	logic        is_last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_ADDR;
	logic [15:0] cfg_data = '0;

	int errors;
	int pending;
	int idle_pct = 16;
	int stall_pct = 16;
	int noise_pct = 8;
	int sent_items = 0;
	logic [7:0]  cur_addr = ADDR_RST;
	logic [15:0] ack_lim = ACK_TO_RST;
	logic [15:0] resp_lim = RESP_TO_RST;

	always #2 clk = ~clk;

	stx_etx_bcc_command_link_top u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
		.cmd_byte(cmd_byte), .cmd_last(cmd_last), .want_response(want_response),
		.rx_byte(rx_byte),
		.res_valid(res_valid), .res_stall(res_stall), .out_kind(out_kind),
		.out_byte(out_byte), .status_code(status_code), .data_count(data_count),
		.is_last(is_last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	stx_etx_bcc_command_link_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
		.cmd_byte(cmd_byte), .cmd_last(cmd_last), .want_response(want_response),
		.rx_byte(rx_byte),
		.res_valid(res_valid), .res_stall(res_stall), .out_kind(out_kind),
		.out_byte(out_byte), .status_code(status_code), .data_count(data_count),
		.is_last(is_last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_stall <= 1'b0;
		else
			res_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return 8'h00;
		if (r < 16)
			return 8'hff;
		if (r < 22)
			return CH_ETX;
		return 8'($urandom);
	endfunction

	function automatic int tick_count(input logic [15:0] lim);
		if (lim <= 16'd40 && $urandom_range(9) == 0)
			return (lim == 16'd0) ? 1 : int'(lim);
		if (lim <= 16'd1)
			return 0;
		return $urandom_range(0, (lim > 16'd4) ? 3 : int'(lim) - 1);
	endfunction

	task automatic push_req(input logic [1:0] kind, input logic [7:0] cb, input logic lst,
			input logic want, input logic [7:0] rb);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		req_valid <= 1'b1;
		req_type <= kind;
		cmd_byte <= cb;
		cmd_last <= lst;
		want_response <= want;
		rx_byte <= rb;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic put_cmd(input logic [7:0] b, input logic lst, input logic want);
		sent_items++;
		push_req(REQ_CMD, b, lst, want, pick_byte());
	endtask

	task automatic put_rx(input logic [7:0] b);
		sent_items++;
		push_req(REQ_RX, pick_byte(), 1'($urandom), 1'($urandom), b);
	endtask

	task automatic put_tick();
		sent_items++;
		push_req(REQ_TICK, pick_byte(), 1'($urandom), 1'($urandom), pick_byte());
	endtask

	// transfers that the block must ignore in the current step of the exchange
	task automatic maybe_noise(input logic [3:0] ok_kinds);
		logic [1:0] k;
		while ($urandom_range(99) < noise_pct) begin
			do k = 2'($urandom_range(3)); while (!ok_kinds[k]);
			push_req(k, pick_byte(), 1'($urandom), 1'($urandom), pick_byte());
		end
	endtask

	task automatic wait_ticks(input int n);
		int i;
		for (i = 0; i < n; i++) begin
			maybe_noise(IGN_WAIT);
			put_tick();
		end
	endtask

	task automatic run_exchange(input int n_cmd, input logic want, input logic early_last,
			input logic [7:0] ack_first, input int ack_ticks, input int resp_ticks,
			input int body_len);
		int p0;
		int n_send;
		int i;
		logic [7:0] x;
		logic [7:0] b;
		p0 = (cur_addr != NO_ADDR) ? 4 : 2;
		n_send = (n_cmd >= FRAME - p0) ? FRAME - p0 : n_cmd;
		for (i = 0; i < n_send; i++) begin
			maybe_noise(IGN_IDLE);
			put_cmd(pick_byte(), (i == n_cmd - 1) || (i == 0 && early_last),
				(i == 0) ? want : 1'($urandom));
		end
		if (n_cmd >= FRAME - p0)
			return;
		wait_ticks(ack_ticks);
		if (ack_ticks >= ((ack_lim == 16'd0) ? 1 : int'(ack_lim)))
			return;
		maybe_noise(IGN_WAIT);
		put_rx(ack_first);
		if (cur_addr != NO_ADDR) begin
			repeat (2) begin
				maybe_noise(IGN_BUSY);
				put_rx(pick_byte());
			end
		end
		if (ack_first != CH_ACK || !want)
			return;
		wait_ticks(resp_ticks);
		if (resp_ticks >= ((resp_lim == 16'd0) ? 1 : int'(resp_lim)))
			return;
		x = '0;
		for (i = 0; i < 3; i++) begin
			maybe_noise((i == 0) ? IGN_WAIT : IGN_BUSY);
			b = pick_byte();
			put_rx(b);
			x = x ^ b;
		end
		for (i = 0; i < body_len && i < FRAME - 3; i++) begin
			b = pick_byte();
			if (b == x)
				b = b ^ 8'h01;
			maybe_noise(IGN_BUSY);
			put_rx(b);
			x = x ^ b;
		end
		if (body_len >= FRAME - 3)
			return;
		maybe_noise(IGN_BUSY);
		put_rx(CH_ETX);
		x = x ^ CH_ETX;
		maybe_noise(IGN_BUSY);
		put_rx(x);
	endtask

	task automatic random_exchange();
		int n;
		int bl;
		logic wr;
		logic el;
		logic [7:0] af;
		n = $urandom_range(2, 9);
		el = ($urandom_range(9) == 0);
		wr = ($urandom_range(99) < 75);
		af = ($urandom_range(99) < 88) ? CH_ACK : pick_byte();
		bl = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 14);
		run_exchange(n, wr, el, af, tick_count(ack_lim), tick_count(resp_lim), bl);
		maybe_noise(IGN_IDLE);
	endtask

	task automatic cfg_put(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// drain the link, then load all registers in one burst
	task automatic configure(input logic [15:0] a, input logic [15:0] ak, input logic [15:0] rs,
			input logic stray);
		req_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (8) @(posedge clk);
		cfg_put(CFG_ADDR, a);
		cfg_put(CFG_ACK_TO, ak);
		cfg_put(CFG_RESP_TO, rs);
		if (stray)
			cfg_put(CFG_NONE, 16'($urandom));
		cfg_valid <= 1'b0;
		cur_addr = a[7:0];
		ack_lim = ak;
		resp_lim = rs;
	endtask

	initial begin
		int phase_n;
		int goal;
		int k;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(16'hffff, 16'd0, 16'd2, 1'b0);
		push_req(REQ_TICK, 8'hff, 1'b1, 1'b1, 8'hff);
		push_req(REQ_RX, 8'h00, 1'b0, 1'b0, CH_ACK);
		push_req(REQ_NONE, 8'hff, 1'b1, 1'b1, 8'h00);
		run_exchange(2, 1'b1, 1'b1, CH_ACK, 1, 0, 0);
		run_exchange(2, 1'b1, 1'b0, NAK, 0, 0, 0);
		run_exchange(2, 1'b1, 1'b0, CH_ACK, 0, 2, 0);
		run_exchange(2, 1'b1, 1'b0, CH_ACK, 0, 1, 0);
		configure(16'h0000, 16'hffff, 16'hffff, 1'b1);
		run_exchange(2, 1'b0, 1'b0, CH_ACK, 2, 0, 0);
		run_exchange(3, 1'b1, 1'b0, CH_ACK, 0, 1, 4);

		configure(16'h00ff, ACK_TO_RST, RESP_TO_RST, 1'b0);
		run_exchange(FRAME - 3, 1'b1, 1'b0, CH_ACK, 0, 0, FRAME);
		run_exchange(FRAME, 1'b0, 1'b0, CH_ACK, 0, 0, 0);

		for (phase_n = 0; phase_n < 4; phase_n++) begin
			case (phase_n)
			0: configure({8'($urandom), 8'($urandom_range(254))},
				16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)), 1'b0);
			1: configure(16'h00ff, 16'd0, 16'd20, 1'b0);
			2: configure({8'($urandom), 8'd254}, 16'd1, 16'd0, 1'b1);
			default: configure({8'($urandom), 8'($urandom)},
				16'($urandom_range(1, 40)), 16'hffff, 1'b0);
			endcase
			idle_pct = (phase_n == 1) ? 0 : 16;
			stall_pct = idle_pct;
			goal = sent_items + 65;
			while (sent_items < goal)
				random_exchange();
		end

		req_valid <= 1'b0;
		@(posedge clk);
		for (k = 0; k < 20000 && pending != 0; k++)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		#3000000;
		$display("testbench: errors");
		$finish;
	end

endmodule
